>>> hdl/rpd_pkg.sv
// Shared types, register indexes and reset values for the rep phase detector.
package rpd_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DWELL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DESCENT_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ASCENT_SPEED  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ASCENT_DEPTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STILLNESS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_REACH     = 3'd5;

  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [7:0]         RST_MIN_DWELL     = 8'd10;
  localparam logic [14:0]        RST_DESCENT_START = 15'd30;
  localparam logic signed [15:0] RST_ASCENT_SPEED  = 16'sd5;
  localparam logic [14:0]        RST_ASCENT_DEPTH  = 15'd100;
  localparam logic [14:0]        RST_STILLNESS     = 15'd3;
  localparam logic signed [15:0] RST_TOP_REACH     = 16'sd20;

  // Phase codes as seen on the result
  localparam logic [1:0] PHASE_CODE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_CODE_ECC  = 2'd1;
  localparam logic [1:0] PHASE_CODE_CONC = 2'd2;

  typedef struct packed {
    logic [7:0]         min_dwell_ticks;
    logic [14:0]        descent_start_margin;
    logic signed [15:0] ascent_speed_margin;
    logic [14:0]        ascent_depth_margin;
    logic [14:0]        stillness_margin;
    logic signed [15:0] top_reach_margin;
  } rpd_cfg_t;

  typedef struct packed {
    logic signed [15:0] current_avg;
    logic signed [15:0] lagging_avg;
    logic signed [15:0] phase_avg;
  } rpd_sample_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       phase_changed;
    logic       rep_done;
  } rpd_result_t;

endpackage

>>> hdl/rpd_stream_if.sv
// Valid/ready stream interface with a typed payload.
interface rpd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/rpd_cfg_regs.sv
// Configuration register file of the rep phase detector.
module rpd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [rpd_pkg::CFG_IDX_W-1:0]    index,
  input  logic [rpd_pkg::CFG_DATA_W-1:0]   wdata,
  output rpd_pkg::rpd_cfg_t                cfg
);
  import rpd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_dwell_ticks      <= RST_MIN_DWELL;
      cfg.descent_start_margin <= RST_DESCENT_START;
      cfg.ascent_speed_margin  <= RST_ASCENT_SPEED;
      cfg.ascent_depth_margin  <= RST_ASCENT_DEPTH;
      cfg.stillness_margin     <= RST_STILLNESS;
      cfg.top_reach_margin     <= RST_TOP_REACH;
    end else if (wr_en) begin
      case (index)
        REG_MIN_DWELL:     cfg.min_dwell_ticks      <= wdata[7:0];
        REG_DESCENT_START: cfg.descent_start_margin <= wdata[14:0];
        REG_ASCENT_SPEED:  cfg.ascent_speed_margin  <= wdata;
        REG_ASCENT_DEPTH:  cfg.ascent_depth_margin  <= wdata[14:0];
        REG_STILLNESS:     cfg.stillness_margin     <= wdata[14:0];
        REG_TOP_REACH:     cfg.top_reach_margin     <= wdata;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

>>> hdl/rpd_phase_core.sv
// Input register, phase state and next-phase logic, result register.
module rpd_phase_core (
  input  logic                 clk,
  input  logic                 rst,
  input  rpd_pkg::rpd_cfg_t    cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rpd_pkg::rpd_sample_t in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rpd_pkg::rpd_result_t out_item
);
  import rpd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_ECC  = 3'b010,
    PH_CONC = 3'b100
  } phase_t;

  logic        s1_valid;
  rpd_sample_t s1_item;
  logic        advance;

  phase_t             phase_reg, phase_next;
  logic [7:0]         dwell_count, dwell_inc, dwell_next;
  logic signed [15:0] top_distance, top_distance_next;
  logic signed [15:0] prior_phase_avg;
  rpd_result_t        result_next;

  logic               dwell_ok, done;
  logic signed [16:0] cur_x, lag_x, pav_x, top_x, prior_x;
  logic signed [16:0] speed, descent_diff, depth_diff, top_diff;
  logic signed [16:0] still_pos, still_neg;

  // Input stage advances whenever the result register is free or draining
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  always_comb begin
    cur_x   = {s1_item.current_avg[15], s1_item.current_avg};
    lag_x   = {s1_item.lagging_avg[15], s1_item.lagging_avg};
    pav_x   = {s1_item.phase_avg[15], s1_item.phase_avg};
    top_x   = {top_distance[15], top_distance};
    prior_x = {prior_phase_avg[15], prior_phase_avg};

    speed        = cur_x - lag_x;
    descent_diff = pav_x - cur_x;
    depth_diff   = prior_x - cur_x;
    top_diff     = top_x - cur_x;
    still_pos    = {2'b00, cfg.stillness_margin};
    still_neg    = -still_pos;

    dwell_inc = (dwell_count == 8'hFF) ? dwell_count : dwell_count + 8'd1;
    dwell_ok  = dwell_inc >= cfg.min_dwell_ticks;

    phase_next        = phase_reg;
    top_distance_next = top_distance;
    done              = 1'b0;

    if (dwell_ok) begin
      unique case (phase_reg)
        PH_IDLE: begin
          if (descent_diff > $signed({2'b00, cfg.descent_start_margin})) begin
            phase_next        = PH_ECC;
            top_distance_next = s1_item.phase_avg;
          end
        end
        PH_ECC: begin
          if (speed >= $signed({cfg.ascent_speed_margin[15], cfg.ascent_speed_margin}) &&
              depth_diff >= $signed({2'b00, cfg.ascent_depth_margin})) begin
            phase_next = PH_CONC;
          end
        end
        PH_CONC: begin
          if (speed <= still_pos && speed >= still_neg &&
              top_diff <= $signed({cfg.top_reach_margin[15], cfg.top_reach_margin})) begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
        end
        default: ;
      endcase
    end

    dwell_next = (phase_next != phase_reg) ? 8'd1 : dwell_inc;

    unique case (phase_next)
      PH_IDLE: result_next.phase = PHASE_CODE_IDLE;
      PH_ECC:  result_next.phase = PHASE_CODE_ECC;
      PH_CONC: result_next.phase = PHASE_CODE_CONC;
      default: result_next.phase = PHASE_CODE_IDLE;
    endcase
    result_next.phase_changed = (phase_next != phase_reg);
    result_next.rep_done      = done;
  end

  // Tracker state moves once per item, as it leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg       <= PH_IDLE;
      dwell_count     <= 8'd0;
      top_distance    <= '0;
      prior_phase_avg <= '0;
    end else if (advance) begin
      phase_reg    <= phase_next;
      dwell_count  <= dwell_next;
      top_distance <= top_distance_next;
      if (phase_next != phase_reg) begin
        prior_phase_avg <= s1_item.phase_avg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_item <= result_next;
    end
  end

endmodule

>>> hdl/rep_phase_detector.sv
// Top level of the rep phase detector.
//
// Tracks one lift through idle, eccentric and concentric phases from three
// distance averages per tick.
// - samples: valid/ready stream, one transfer per tick carrying current_avg,
//   lagging_avg and phase_avg (signed mm).
// - results: valid/ready stream, exactly one transfer per sample carrying
//   phase, phase_changed and rep_done.
// - cfg_wr_en/cfg_index/cfg_wdata: register writes, taken on any edge with
//   cfg_wr_en high; write only while no sample is in flight.
// A sample passes the input register, then the result register, before its
// result is valid. Throughput: one sample per cycle while results does not
// stall, held by the single next-phase logic between the two registers.
// When results stalls, the input register still takes one more sample and
// samples.ready drops once both registers hold data; no data is lost.
// Reset (rst, synchronous): phase idle, dwell counter, top-of-rep and prior
// phase average cleared, registers back to their defaults, pipeline empty.
module rep_phase_detector (
  input  logic                           clk,
  input  logic                           rst,
  rpd_stream_if.sink                     samples,
  rpd_stream_if.source                   results,
  input  logic                           cfg_wr_en,
  input  logic [rpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rpd_pkg::*;

  rpd_cfg_t cfg;

  rpd_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  rpd_phase_core u_phase_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .in_item   (samples.data),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_item  (results.data)
  );

endmodule

>>> test/tb_rep_phase_detector.sv
`timescale 1ns / 1ps
// Self-checking testbench for rep_phase_detector: sample stream in, phase stream out.
module tb_rep_phase_detector;
  import rpd_pkg::*;

  localparam int HALF_PERIOD     = 4;       // 8 ns clock
  localparam int RESET_CYCLES    = 7;
  localparam int MAX_GAP         = 14;      // longest idle drawn by either side
  localparam int DRAIN_CYCLES    = 8;       // two pipeline registers plus margin
  localparam int HOLD_OFF_CYCLES = 60;      // long output stall for backpressure
  localparam int CYCLE_LIMIT     = 200000;

  // Register indexes the block does not decode; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rpd_stream_if #(.payload_t(rpd_sample_t)) samples_if ();
  rpd_stream_if #(.payload_t(rpd_result_t)) results_if ();

  rep_phase_detector dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples_if),
    .results   (results_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the block: register file plus the lift tracking state.
  // ---------------------------------------------------------------------------
  rpd_cfg_t           shadow_cfg;
  logic [1:0]         lift_phase;
  logic [7:0]         dwell_ticks;
  logic signed [15:0] shadow_top;
  logic signed [15:0] prior_avg;

  rpd_result_t expected_phases[$];   // one entry per accepted sample, in order
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  bit          quiet        = 1'b0;  // no idling on either side while set
  int unsigned hold_off_req = 0;     // handed to the receiver, which counts it down

  function automatic void reset_shadow();
    shadow_cfg.min_dwell_ticks      = RST_MIN_DWELL;
    shadow_cfg.descent_start_margin = RST_DESCENT_START;
    shadow_cfg.ascent_speed_margin  = RST_ASCENT_SPEED;
    shadow_cfg.ascent_depth_margin  = RST_ASCENT_DEPTH;
    shadow_cfg.stillness_margin     = RST_STILLNESS;
    shadow_cfg.top_reach_margin     = RST_TOP_REACH;
    lift_phase  = PHASE_CODE_IDLE;
    dwell_ticks = '0;
    shadow_top  = '0;
    prior_avg   = '0;
  endfunction

  // Only the low bits of a write land in the narrower registers.
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_MIN_DWELL:     shadow_cfg.min_dwell_ticks      = value[7:0];
      REG_DESCENT_START: shadow_cfg.descent_start_margin = value[14:0];
      REG_ASCENT_SPEED:  shadow_cfg.ascent_speed_margin  = value;
      REG_ASCENT_DEPTH:  shadow_cfg.ascent_depth_margin  = value[14:0];
      REG_STILLNESS:     shadow_cfg.stillness_margin     = value[14:0];
      REG_TOP_REACH:     shadow_cfg.top_reach_margin     = value;
      default: ;
    endcase
  endfunction

  // One tick of the phase tracker. All differences are taken in 32-bit ints,
  // so the 17-bit exact arithmetic of the block never wraps here either.
  function automatic rpd_result_t advance_phase(input rpd_sample_t s);
    rpd_result_t r;
    logic [1:0]  nxt;
    bit          done;
    int          cur, lag, pav, speed, mag;
    cur   = $signed(s.current_avg);
    lag   = $signed(s.lagging_avg);
    pav   = $signed(s.phase_avg);
    speed = cur - lag;
    mag   = (speed < 0) ? -speed : speed;
    nxt   = lift_phase;
    done  = 1'b0;
    // Counter saturates at 255 instead of wrapping back under the dwell limit.
    if (dwell_ticks != 8'hFF) dwell_ticks++;
    if (dwell_ticks >= shadow_cfg.min_dwell_ticks) begin
      case (lift_phase)
        PHASE_CODE_IDLE: begin
          if (pav - cur > int'(shadow_cfg.descent_start_margin)) begin
            shadow_top = s.phase_avg;
            nxt        = PHASE_CODE_ECC;
          end
        end
        PHASE_CODE_ECC: begin
          if (speed >= int'($signed(shadow_cfg.ascent_speed_margin)) &&
              int'(prior_avg) - cur >= int'(shadow_cfg.ascent_depth_margin)) begin
            nxt = PHASE_CODE_CONC;
          end
        end
        PHASE_CODE_CONC: begin
          if (mag <= int'(shadow_cfg.stillness_margin) &&
              int'(shadow_top) - cur <= int'($signed(shadow_cfg.top_reach_margin))) begin
            nxt  = PHASE_CODE_IDLE;
            done = 1'b1;
          end
        end
        default: ;  // unused code holds
      endcase
    end
    r.phase_changed = (nxt != lift_phase);
    if (nxt != lift_phase) begin
      prior_avg   = s.phase_avg;
      dwell_ticks = 8'd1;
      lift_phase  = nxt;
    end
    r.phase    = lift_phase;
    r.rep_done = done;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sample generation
  // ---------------------------------------------------------------------------
  function automatic logic signed [15:0] sat16(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // Builds a sample aimed at the move out of the present phase. Each slack is
  // the distance past its threshold: both >= 0 passes, a negative one fails.
  // Idle only uses slack_a. Near the 16-bit limits clamping may bend the aim;
  // the shadow model decides the outcome either way.
  function automatic rpd_sample_t aim_sample(input int slack_a, input int slack_b);
    rpd_sample_t s;
    int cur, lag, pav, need, mag;
    cur = int'($urandom_range(0, 40000)) - 20000;
    lag = cur + int'($urandom_range(0, 8)) - 4;
    pav = cur + int'($urandom_range(0, 200)) - 100;
    case (lift_phase)
      PHASE_CODE_IDLE: begin
        need = int'(shadow_cfg.descent_start_margin) + 1 + slack_a;
        pav  = cur + need;
        if (pav > 32767) begin
          pav = 32767;
          cur = pav - need;
          lag = cur;
        end
      end
      PHASE_CODE_ECC: begin
        cur = int'(prior_avg) - (int'(shadow_cfg.ascent_depth_margin) + slack_b);
        lag = cur - (int'($signed(shadow_cfg.ascent_speed_margin)) + slack_a);
        pav = cur + int'($urandom_range(0, 200)) - 100;
      end
      PHASE_CODE_CONC: begin
        cur = int'(shadow_top) - (int'($signed(shadow_cfg.top_reach_margin)) - slack_b);
        mag = int'(shadow_cfg.stillness_margin) - slack_a;
        if (mag < 0) mag = 0;
        lag = $urandom_range(0, 1) ? cur - mag : cur + mag;
        pav = cur + int'($urandom_range(0, 200)) - 100;
      end
      default: ;
    endcase
    s.current_avg = sat16(cur);
    s.lagging_avg = sat16(lag);
    s.phase_avg   = sat16(pav);
    return s;
  endfunction

  // Mostly small passing slacks, sometimes just short of the threshold.
  function automatic int draw_slack();
    if ($urandom_range(0, 9) < 7) return int'($urandom_range(0, 2));
    return -int'($urandom_range(1, 3));
  endfunction

  // Mix: raw noise over the full range, aimed moves, and samples that hold.
  function automatic rpd_sample_t random_item();
    rpd_sample_t s;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      s.current_avg = 16'($urandom());
      s.lagging_avg = 16'($urandom());
      s.phase_avg   = 16'($urandom());
    end else if (pick < 60) begin
      s = aim_sample(draw_slack(), draw_slack());
    end else begin
      s = aim_sample(-int'($urandom_range(1, 40)), -int'($urandom_range(1, 40)));
    end
    return s;
  endfunction

  function automatic rpd_cfg_t random_cfg();
    rpd_cfg_t c;
    c.min_dwell_ticks      = 8'($urandom_range(1, 6));
    c.descent_start_margin = 15'($urandom_range(0, 200));
    c.ascent_speed_margin  = 16'(int'($urandom_range(0, 60)) - 20);
    c.ascent_depth_margin  = 15'($urandom_range(0, 300));
    c.stillness_margin     = 15'($urandom_range(0, 20));
    c.top_reach_margin     = 16'(int'($urandom_range(0, 150)) - 50);
    return c;
  endfunction

  function automatic int draw_gap();
    if (quiet || $urandom_range(0, 1) == 0) return 0;
    return int'($urandom_range(0, MAX_GAP));
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Offers one sample and returns at the edge of its transfer. valid is left
  // high so a back-to-back sample keeps it up without a glitch.
  task automatic send_sample(input rpd_sample_t s);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples_if.valid <= 1'b1;
    samples_if.data  <= s;
    do @(posedge clk); while (!samples_if.ready);
    expected_phases.push_back(advance_phase(s));
  endtask

  // Registers only change with the pipeline empty.
  task automatic settle();
    samples_if.valid <= 1'b0;
    while (expected_phases.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    apply_reg(idx, value);
  endtask

  // Unused upper bits of the narrow registers get random junk.
  task automatic load_config(input rpd_cfg_t c);
    write_reg(REG_MIN_DWELL,     {8'($urandom()), c.min_dwell_ticks});
    write_reg(REG_DESCENT_START, {1'($urandom()), c.descent_start_margin});
    write_reg(REG_ASCENT_SPEED,  c.ascent_speed_margin);
    write_reg(REG_ASCENT_DEPTH,  {1'($urandom()), c.ascent_depth_margin});
    write_reg(REG_STILLNESS,     {1'($urandom()), c.stillness_margin});
    write_reg(REG_TOP_REACH,     c.top_reach_margin);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: checks every transfer and paces ready.
  // ---------------------------------------------------------------------------
  function automatic void report_field(input string field, input logic [1:0] want,
                                       input logic [1:0] got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    mismatches++;
  endfunction

  function automatic void check_result(input rpd_result_t got);
    rpd_result_t want;
    if (expected_phases.size() == 0) begin
      $display("%0t: result with nothing expected, actual phase %0d changed %0b done %0b",
               $time, got.phase, got.phase_changed, got.rep_done);
      mismatches++;
      return;
    end
    want = expected_phases.pop_front();
    if (got.phase !== want.phase) report_field("phase", want.phase, got.phase);
    if (got.phase_changed !== want.phase_changed)
      report_field("phase_changed", want.phase_changed, got.phase_changed);
    if (got.rep_done !== want.rep_done) report_field("rep_done", want.rep_done, got.rep_done);
  endfunction

  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;

  // After each transfer the receiver draws a stall; a hold-off request from a
  // test overrides it with a long stretch of ready low.
  always @(posedge clk) begin
    if (!rst) begin
      if (results_if.valid && results_if.ready) begin
        check_result(results_if.data);
        stall_left = draw_gap();
      end
      if (hold_off_req != 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        results_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_phases.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    forever #(HALF_PERIOD) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Full-scale field values under the reset register values; the default dwell
  // of 10 keeps the phase idle through these few ticks.
  task automatic test_field_extremes();
    rpd_sample_t s;
    s = '{16'sh8000, 16'sh8000, 16'sh8000};
    send_sample(s);
    s = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
    send_sample(s);
    s = '{16'sh8000, 16'sh7FFF, 16'sh7FFF};
    send_sample(s);
    settle();
  endtask

  // One rep walked through each threshold: first just short, then exactly on.
  task automatic test_thresholds();
    rpd_cfg_t c;
    int       slack_a[8] = '{-1, 0, -1,  0, 0, -1,  0, 0};
    int       slack_b[8] = '{ 0, 0,  0, -1, 0,  0, -1, 0};
    c = shadow_cfg;
    c.min_dwell_ticks = 8'd1;
    write_reg(REG_UNUSED_LO, 16'($urandom()));
    write_reg(REG_UNUSED_HI, 16'($urandom()));
    load_config(c);
    for (int i = 0; i < 8; i++) send_sample(aim_sample(slack_a[i], slack_b[i]));
    settle();
  endtask

  // Minimum dwell of zero: every tick may move, even right after a change.
  task automatic test_zero_dwell();
    write_reg(REG_MIN_DWELL, {8'($urandom()), 8'd0});
    repeat (5) send_sample(aim_sample(0, 0));
    settle();
  endtask

  // Low and high register extremes.
  task automatic test_config_extremes();
    rpd_cfg_t c;
    c.min_dwell_ticks      = 8'd1;
    c.descent_start_margin = '0;
    c.ascent_speed_margin  = 16'sh8000;
    c.ascent_depth_margin  = '0;
    c.stillness_margin     = '0;
    c.top_reach_margin     = 16'sh8000;
    load_config(c);
    repeat (20) send_sample(random_item());
    settle();
    c.min_dwell_ticks      = 8'd2;
    c.descent_start_margin = 15'h7FFF;
    c.ascent_speed_margin  = 16'sh7FFF;
    c.ascent_depth_margin  = 15'h7FFF;
    c.stillness_margin     = 15'h7FFF;
    c.top_reach_margin     = 16'sh7FFF;
    load_config(c);
    repeat (20) send_sample(random_item());
    settle();
  endtask

  // Bulk of the run: random settings, one phase without any idling.
  task automatic test_random_reps();
    for (int ph = 0; ph < 3; ph++) begin
      load_config(random_cfg());
      quiet = (ph == 1);
      repeat (35) send_sample(random_item());
      quiet = 1'b0;
      settle();
    end
  endtask

  // Receiver stops for a long stretch while samples keep coming back to back:
  // both pipeline registers fill and samples.ready must drop.
  task automatic test_output_backpressure();
    load_config(random_cfg());
    quiet        = 1'b1;
    hold_off_req = HOLD_OFF_CYCLES;
    repeat (24) send_sample(random_item());
    quiet = 1'b0;
    settle();
  endtask

  // Dwell of 255 with more than 256 ticks held: a wrapping counter would fall
  // back under the limit and block the move at the end.
  task automatic test_dwell_saturation();
    rpd_cfg_t c;
    c = random_cfg();
    c.min_dwell_ticks = 8'd255;
    load_config(c);
    repeat (260) begin
      send_sample(aim_sample(-int'($urandom_range(1, 20)), -int'($urandom_range(1, 20))));
    end
    repeat (3) send_sample(aim_sample(0, 0));
    settle();
  endtask

  initial begin
    rst              <= 1'b1;
    cfg_wr_en        <= 1'b0;
    cfg_index        <= '0;
    cfg_wdata        <= '0;
    samples_if.valid <= 1'b0;
    samples_if.data  <= '0;
    results_if.ready <= 1'b0;
    reset_shadow();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_field_extremes();
    test_thresholds();
    test_zero_dwell();
    test_config_extremes();
    test_random_reps();
    test_output_backpressure();
    test_dwell_saturation();

    settle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
